### src/ntpb_pkg.sv
`default_nettype none
package ntpb_pkg;

    localparam int STAMP_W = 63;
    localparam int POSE_W  = 224;
    localparam int GAP_W   = 30;
    localparam logic [GAP_W-1:0] GAP_RESET = 30'd50000000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [POSE_W-1:0]  pose;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SCMP,
        ST_ICHK,
        ST_ICMP,
        ST_INEQ,
        ST_SHRD,
        ST_SHWR,
        ST_PLACE,
        ST_LRDA,
        ST_LRDB,
        ST_LCAP,
        ST_LDIST,
        ST_LPICK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

### src/ntpb_mem.sv
`default_nettype none
module ntpb_mem #(
    parameter int DEPTH = 4096
) (
    input  wire                         clk,
    input  wire                         we,
    input  wire [$clog2(DEPTH)-1:0]     waddr,
    input  wire ntpb_pkg::entry_t       wdata,
    input  wire [$clog2(DEPTH)-1:0]     raddr,
    output ntpb_pkg::entry_t            rdata
);

    ntpb_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/ntpb_ctrl.sv
`default_nettype none
module ntpb_ctrl #(
    parameter int CAPACITY = 4096
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 in_op,
    input  wire [ntpb_pkg::STAMP_W-1:0]         in_stamp,
    input  wire [ntpb_pkg::POSE_W-1:0]          in_pose,
    input  wire [ntpb_pkg::GAP_W-1:0]           gap,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                out_found,
    output logic [ntpb_pkg::POSE_W-1:0]         out_pose,
    output logic                                mem_we,
    output logic [$clog2(CAPACITY)-1:0]         mem_waddr,
    output ntpb_pkg::entry_t                    mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]         mem_raddr,
    input  wire ntpb_pkg::entry_t               mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    ntpb_pkg::state_t state_reg, state_next;
    logic                          op_reg, op_next;
    logic [ntpb_pkg::STAMP_W-1:0]  key_reg, key_next;
    logic [ntpb_pkg::POSE_W-1:0]   pose_reg, pose_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] src_reg, src_next, dst_reg, dst_next, place_reg, place_next;
    logic          full_reg, full_next;
    ntpb_pkg::entry_t prev_reg, prev_next, nxt_reg, nxt_next;
    logic [ntpb_pkg::STAMP_W-1:0]  dp_reg, dp_next, du_reg, du_next;
    logic                          rfound_reg, rfound_next;
    logic [ntpb_pkg::POSE_W-1:0]   rpose_reg, rpose_next;
    logic                          ov_reg, ov_next;
    logic                          of_reg, of_next;
    logic [ntpb_pkg::POSE_W-1:0]   opose_reg, opose_next;

    logic [CW:0]                   sum;
    logic                          use_prev;
    logic [ntpb_pkg::STAMP_W-1:0]  dsel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ntpb_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pose_reg   <= pose_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        place_reg  <= place_next;
        full_reg   <= full_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        dp_reg     <= dp_next;
        du_reg     <= du_next;
        rfound_reg <= rfound_next;
        rpose_reg  <= rpose_next;
        of_reg     <= of_next;
        opose_reg  <= opose_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pose_next   = pose_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        cnt_next    = cnt_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        place_next  = place_reg;
        full_next   = full_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        dp_next     = dp_reg;
        du_next     = du_reg;
        rfound_next = rfound_reg;
        rpose_next  = rpose_reg;
        of_next     = of_reg;
        opose_next  = opose_reg;
        ov_next     = ov_reg && !out_ready;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        sum         = {1'b0, lo_reg} + {1'b0, hi_reg};
        use_prev    = (lo_reg >= cnt_reg) || ((lo_reg != '0) && (dp_reg <= du_reg));
        dsel        = use_prev ? dp_reg : du_reg;
        in_ready    = (state_reg == ntpb_pkg::ST_IDLE);

        case (state_reg)
            ntpb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    key_next   = in_stamp;
                    pose_next  = in_pose;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    state_next = ntpb_pkg::ST_SRCH;
                end
            end
            ntpb_pkg::ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = sum[CW:1];
                    mem_raddr  = sum[AW:1];
                    state_next = ntpb_pkg::ST_SCMP;
                end
                else if (op_reg == ntpb_pkg::OP_INSERT)
                begin
                    state_next = ntpb_pkg::ST_ICHK;
                end
                else if (cnt_reg == '0)
                begin
                    rfound_next = 1'b0;
                    rpose_next  = '0;
                    state_next  = ntpb_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ntpb_pkg::ST_LRDA;
                end
            end
            ntpb_pkg::ST_SCMP:
            begin
                if (mem_rdata.stamp < key_reg)
                begin
                    lo_next = mid_reg + ONE;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ntpb_pkg::ST_SRCH;
            end
            ntpb_pkg::ST_ICHK:
            begin
                mem_raddr  = lo_reg[AW-1:0];
                state_next = (lo_reg < cnt_reg) ? ntpb_pkg::ST_ICMP : ntpb_pkg::ST_INEQ;
            end
            ntpb_pkg::ST_ICMP:
            begin
                if (mem_rdata.stamp == key_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = lo_reg[AW-1:0];
                    mem_wdata   = {key_reg, pose_reg};
                    rfound_next = 1'b0;
                    rpose_next  = '0;
                    state_next  = ntpb_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ntpb_pkg::ST_INEQ;
                end
            end
            ntpb_pkg::ST_INEQ:
            begin
                rfound_next = 1'b0;
                rpose_next  = '0;
                if (cnt_reg >= CAP)
                begin
                    full_next = 1'b1;
                    // new key below everything: it would be evicted at once
                    if (lo_reg == '0)
                    begin
                        state_next = ntpb_pkg::ST_DONE;
                    end
                    else
                    begin
                        src_next   = ONE;
                        dst_next   = '0;
                        place_next = lo_reg - ONE;
                        state_next = (lo_reg > ONE) ? ntpb_pkg::ST_SHRD : ntpb_pkg::ST_PLACE;
                    end
                end
                else
                begin
                    full_next  = 1'b0;
                    dst_next   = cnt_reg;
                    src_next   = cnt_reg - ONE;
                    place_next = lo_reg;
                    state_next = (cnt_reg > lo_reg) ? ntpb_pkg::ST_SHRD : ntpb_pkg::ST_PLACE;
                end
            end
            ntpb_pkg::ST_SHRD:
            begin
                mem_raddr  = src_reg[AW-1:0];
                state_next = ntpb_pkg::ST_SHWR;
            end
            ntpb_pkg::ST_SHWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if (full_reg)
                begin
                    src_next   = src_reg + ONE;
                    dst_next   = dst_reg + ONE;
                    state_next = (src_reg + ONE < lo_reg) ? ntpb_pkg::ST_SHRD
                                                          : ntpb_pkg::ST_PLACE;
                end
                else
                begin
                    src_next   = src_reg - ONE;
                    dst_next   = dst_reg - ONE;
                    state_next = (dst_reg - ONE > lo_reg) ? ntpb_pkg::ST_SHRD
                                                          : ntpb_pkg::ST_PLACE;
                end
            end
            ntpb_pkg::ST_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = place_reg[AW-1:0];
                mem_wdata = {key_reg, pose_reg};
                if (!full_reg)
                begin
                    cnt_next = cnt_reg + ONE;
                end
                state_next = ntpb_pkg::ST_DONE;
            end
            ntpb_pkg::ST_LRDA:
            begin
                mem_raddr  = (lo_reg == '0) ? '0 : AW'(lo_reg - ONE);
                state_next = ntpb_pkg::ST_LRDB;
            end
            ntpb_pkg::ST_LRDB:
            begin
                prev_next  = mem_rdata;
                mem_raddr  = (lo_reg < cnt_reg) ? lo_reg[AW-1:0] : AW'(lo_reg - ONE);
                state_next = ntpb_pkg::ST_LCAP;
            end
            ntpb_pkg::ST_LCAP:
            begin
                nxt_next   = mem_rdata;
                state_next = ntpb_pkg::ST_LDIST;
            end
            ntpb_pkg::ST_LDIST:
            begin
                // prev below the key, nxt at or above it (not at the ends)
                dp_next    = key_reg - prev_reg.stamp;
                du_next    = nxt_reg.stamp - key_reg;
                state_next = ntpb_pkg::ST_LPICK;
            end
            ntpb_pkg::ST_LPICK:
            begin
                rfound_next = (dsel <= {{(ntpb_pkg::STAMP_W-ntpb_pkg::GAP_W){1'b0}}, gap});
                if (dsel <= {{(ntpb_pkg::STAMP_W-ntpb_pkg::GAP_W){1'b0}}, gap})
                begin
                    rpose_next = use_prev ? prev_reg.pose : nxt_reg.pose;
                end
                else
                begin
                    rpose_next = '0;
                end
                state_next = ntpb_pkg::ST_DONE;
            end
            ntpb_pkg::ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    of_next    = rfound_reg;
                    opose_next = rpose_reg;
                    state_next = ntpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ntpb_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_found = of_reg;
    assign out_pose  = opose_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP)
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ntpb_pkg::ST_PLACE) |=> (cnt_reg == $past(cnt_reg)))
        else $error("entry count changed outside placement");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ntpb_pkg::ST_SRCH) |-> (lo_reg <= hi_reg && hi_reg <= cnt_reg))
        else $error("search bounds crossed");

    a_insert_nf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ntpb_pkg::ST_DONE && op_reg == ntpb_pkg::OP_INSERT) |-> !rfound_reg)
        else $error("insert reported a match");

endmodule
`default_nettype wire

### src/nearest_timestamp_pose_buffer_unit.sv
// Nearest-timestamp pose table.
// Input stream s_*: s_tuser is the operation (0 insert, 1 lookup); s_tdata carries
// the timestamp and the pose. An insert stores the pose under its timestamp,
// overwriting an equal key; on a full table the oldest entry is dropped.
// A lookup returns the stored pose nearest the query time (ties go to the
// earlier entry) when the gap is within the tolerance register.
// Output stream m_*: one transaction per input transaction, in order; m_tuser
// is the found flag, m_tdata the pose (zero when not found or on insert).
// A lookup is a binary search over the table, each step one read and one compare.
// An out-of-order insert moves every later entry (on a full table every earlier
// one but the oldest, which is dropped) one slot over, each entry read and then
// written back through the table's read and write ports.
// One transaction is in progress at a time; the next is taken as soon as the
// result sits in the output register, even if the receiver stalls it.
// Reset empties the table at once (no clearing pass) and loads the tolerance
// with 50 ms. cfg_we writes the tolerance; write it only while idle.
`default_nettype none
module nearest_timestamp_pose_buffer_unit #(
    parameter int CAPACITY = 4096
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [287:0]  s_tdata, // stamp_ns, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    input  wire          s_tuser,   // operation
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [223:0] m_tdata,   // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    output logic         m_tuser,   // found
    input  wire          cfg_we,
    input  wire [29:0]   cfg_wdata
);

    localparam int AW = $clog2(CAPACITY);

    logic [ntpb_pkg::GAP_W-1:0] gap_reg, gap_next;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    ntpb_pkg::entry_t           mem_wdata, mem_rdata;

    always_comb
    begin
        gap_next = cfg_we ? cfg_wdata : gap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= ntpb_pkg::GAP_RESET;
        end
        else
        begin
            gap_reg <= gap_next;
        end
    end

    ntpb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_stamp  (s_tdata[62:0]),
        .in_pose   (s_tdata[286:63]),
        .gap       (gap_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (m_tuser),
        .out_pose  (m_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ntpb_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

### tb/sv/tb_nearest_timestamp_pose_buffer_unit.sv
`default_nettype none
module tb_nearest_timestamp_pose_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 4096;
    localparam int IDLE_MAX  = 100000;
    localparam int RAND_ITEMS = 1700;

    typedef logic [6:0][31:0] pose_t;   // pos_x lowest, quat_z highest

    typedef struct {
        logic  found;
        pose_t pose;
    } pose_match_t;

    typedef struct {
        logic                         op;
        logic [ntpb_pkg::STAMP_W-1:0] stamp;
        pose_t                        pose;
        bit                           typed;
        pose_match_t                  want;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [287:0]                 s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [223:0]                 m_tdata;
    logic                         m_tuser;
    logic                         cfg_we;
    logic [ntpb_pkg::GAP_W-1:0]   cfg_wdata;

    // table mirror
    logic [ntpb_pkg::STAMP_W-1:0] tbl_stamp [DEPTH];
    pose_t                        tbl_pose  [DEPTH];
    int                           tbl_count;
    logic [ntpb_pkg::GAP_W-1:0]   tol_ns;

    pose_match_t                  pending_q [$];
    int                           err_cnt;
    int                           burst_left;
    int                           stall_left;
    int                           stall_pct;
    int                           idle_cycles;
    logic [ntpb_pkg::STAMP_W-1:0] cursor;

    string fld_name [7] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_quat_w",
                            "out_quat_x", "out_quat_y", "out_quat_z"};

    nearest_timestamp_pose_buffer_unit #(.CAPACITY(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [ntpb_pkg::STAMP_W-1:0] rand_stamp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ntpb_pkg::STAMP_W-1:0];
    endfunction

    function automatic pose_t rand_pose();
        pose_t p;
        for (int k = 0; k < 7; k++)
            p[k] = $urandom;
        return p;
    endfunction

    function automatic logic [ntpb_pkg::STAMP_W-1:0] gap_of(logic [ntpb_pkg::STAMP_W-1:0] a,
                                                             logic [ntpb_pkg::STAMP_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // first slot whose stamp is >= key
    function automatic int first_not_below(logic [ntpb_pkg::STAMP_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_stamp[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic void store_pose(logic [ntpb_pkg::STAMP_W-1:0] t, pose_t p);
        int pos;
        pos = first_not_below(t);
        if (pos < tbl_count && tbl_stamp[pos] == t) begin
            tbl_pose[pos] = p;
            return;
        end
        if (tbl_count >= DEPTH) begin
            // full: oldest drops out; a key below all of them goes straight out
            if (pos == 0)
                return;
            for (int k = 0; k + 1 < pos; k++) begin
                tbl_stamp[k] = tbl_stamp[k+1];
                tbl_pose[k]  = tbl_pose[k+1];
            end
            tbl_stamp[pos-1] = t;
            tbl_pose[pos-1]  = p;
            return;
        end
        for (int k = tbl_count; k > pos; k--) begin
            tbl_stamp[k] = tbl_stamp[k-1];
            tbl_pose[k]  = tbl_pose[k-1];
        end
        tbl_stamp[pos] = t;
        tbl_pose[pos]  = p;
        tbl_count++;
    endfunction

    function automatic pose_match_t nearest_pose(logic op, logic [ntpb_pkg::STAMP_W-1:0] t,
                                                 pose_t p);
        pose_match_t r;
        int up;
        int pick;
        r.found = 1'b0;
        r.pose  = '0;
        if (op == ntpb_pkg::OP_INSERT) begin
            store_pose(t, p);
            return r;
        end
        if (tbl_count == 0)
            return r;
        up = first_not_below(t);
        if (up == 0)
            pick = 0;
        else if (up >= tbl_count)
            pick = tbl_count - 1;
        else if (gap_of(tbl_stamp[up-1], t) <= gap_of(tbl_stamp[up], t))
            pick = up - 1;
        else
            pick = up;
        if (gap_of(tbl_stamp[pick], t) > tol_ns)
            return r;
        r.found = 1'b1;
        r.pose  = tbl_pose[pick];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic push_item(logic op, logic [ntpb_pkg::STAMP_W-1:0] st, pose_t p,
                             bit typed, pose_match_t want);
        pose_match_t r;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, p, st};
        do
            @(posedge clk);
        while (!s_tready);
        r = nearest_pose(op, st, p);
        pending_q.insert(pending_q.size(), typed ? want : r);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
        burst_left = 0;
    endtask

    task automatic set_tolerance(logic [ntpb_pkg::GAP_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tol_ns = v;
    endtask

    function automatic logic [ntpb_pkg::STAMP_W-1:0] pick_query();
        int idx;
        logic [ntpb_pkg::STAMP_W-1:0] base;
        logic [31:0] off;
        if (tbl_count == 0)
            return rand_stamp();
        idx  = $urandom_range(0, tbl_count - 1);
        base = tbl_stamp[idx];
        off  = $urandom_range(0, tol_ns + 1000);
        case ($urandom_range(0, 9))
            0: return base;
            1, 2: return base + off;
            3: return (base > off) ? base - off : '0;
            4: return base + tol_ns;
            5: return base + tol_ns + 1;
            6: return (base > tol_ns) ? base - tol_ns - 1 : base;
            7: begin
                // midway between neighbours, an exact tie when the spacing is even
                if (idx + 1 < tbl_count)
                    return base + (tbl_stamp[idx+1] - base) / 2;
                return base + $urandom;
            end
            8: return rand_stamp();
            default: return tbl_stamp[tbl_count-1] + $urandom_range(0, 100);
        endcase
    endfunction

    function automatic logic [ntpb_pkg::STAMP_W-1:0] pick_key();
        int idx;
        idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
        case ($urandom_range(0, 49))
            0: return rand_stamp();
            1, 2, 3, 4, 5: return (tbl_count > 0) ? tbl_stamp[idx] : cursor;
            6, 7, 8, 9, 10: return (tbl_count > 0) ? tbl_stamp[idx] + $urandom_range(1, 999)
                                                  : cursor;
            default: begin
                cursor = cursor + $urandom_range(1, 40000000);
                return cursor;
            end
        endcase
    endfunction

    task automatic random_items(int n, int lookup_pct);
        pose_match_t none;
        none = '{1'b0, '0};
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < lookup_pct)
                push_item(ntpb_pkg::OP_LOOKUP, pick_query(), rand_pose(), 0, none);
            else
                push_item(ntpb_pkg::OP_INSERT, pick_key(), rand_pose(), 0, none);
            if (i == n / 2 && n > 100)
                drain();
        end
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 15);
        end
    end

    always @(posedge clk)
    begin
        pose_match_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                report("unexpected transaction", m_tdata[31:0], '0);
            end else begin
                want = pending_q.pop_front();
                if (m_tuser !== want.found)
                    report("found", m_tuser, want.found);
                for (int k = 0; k < 7; k++)
                    if (m_tdata[k*32 +: 32] !== want.pose[k])
                        report(fld_name[k], m_tdata[k*32 +: 32], want.pose[k]);
            end
        end
    end

    // nothing accepted for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        pose_t pa;
        pose_t pb;
        pose_t pc;
        pose_t pd;
        pose_t pe;
        pose_match_t none;
        logic [ntpb_pkg::STAMP_W-1:0] top;
        logic [31:0] rnd_gap;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ntpb_pkg::OP_INSERT;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        err_cnt     = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_pct   = 30;
        idle_cycles = 0;
        tbl_count   = 0;
        tol_ns      = ntpb_pkg::GAP_RESET;
        cursor      = 63'd100000;
        top         = {ntpb_pkg::STAMP_W{1'b1}};
        none        = '{1'b0, '0};

        pa = rand_pose();
        pb = {7{32'h8000_0000}};
        pc = {7{32'h7FFF_FFFF}};
        pd = {7{32'hFFFF_FFFF}};
        pe = rand_pose();

        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd1000, pa, 1, none}); // empty table
        rows.insert(rows.size(), '{ntpb_pkg::OP_INSERT, 63'd1000, pa, 1, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_INSERT, 63'd0, pb, 1, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_INSERT, top, pc, 1, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_INSERT, 63'd1000, pd, 1, none}); // overwrite
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd1000, pa, 1, '{1'b1, pd}});
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd500, pa, 0, none});  // tie
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, top, pa, 1, '{1'b1, pc}});
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, top - 1, pa, 0, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd3000, pa, 0, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_INSERT, 63'd2000, pe, 0, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd1500, pa, 0, none}); // tie
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'h4000_0000_0000_0000, pa, 0, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_INSERT, 63'd500, '0, 0, none});
        // exactly at tolerance, then one past
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd50002000, pa, 0, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd50002001, pa, 0, none});
        rows.insert(rows.size(), '{ntpb_pkg::OP_LOOKUP, 63'd0, pa, 1, '{1'b1, pb}});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            push_item(rows[i].op, rows[i].stamp, rows[i].pose, rows[i].typed, rows[i].want);

        stall_pct = 0;
        random_items(RAND_ITEMS / 6, 55);
        set_tolerance('0);
        stall_pct = 50;
        random_items(RAND_ITEMS / 6, 55);
        set_tolerance({ntpb_pkg::GAP_W{1'b1}});
        stall_pct = 10;
        random_items(RAND_ITEMS / 6, 55);
        set_tolerance(30'd1000000000);
        stall_pct = 80;
        random_items(RAND_ITEMS / 6, 55);
        set_tolerance(30'd5000);
        stall_pct = 20;
        random_items(RAND_ITEMS / 6, 55);
        rnd_gap = $urandom_range(0, 1000000000);
        set_tolerance(rnd_gap[ntpb_pkg::GAP_W-1:0]);
        stall_pct = 0;
        random_items(RAND_ITEMS / 6, 55);

        // fill to capacity with appends, then exercise eviction
        set_tolerance(ntpb_pkg::GAP_RESET);
        stall_pct = 5;
        while (tbl_count < DEPTH) begin
            cursor = cursor + $urandom_range(1, 1000);
            push_item(ntpb_pkg::OP_INSERT, cursor, rand_pose(), 0, none);
        end
        stall_pct = 30;
        for (int i = 0; i < 60; i++) begin
            case ($urandom_range(0, 5))
                0: push_item(ntpb_pkg::OP_INSERT, tbl_stamp[0] - (tbl_stamp[0] > 0),
                             rand_pose(), 0, none);
                1: push_item(ntpb_pkg::OP_INSERT, tbl_stamp[$urandom_range(0, DEPTH - 1)],
                             rand_pose(), 0, none);
                2: push_item(ntpb_pkg::OP_INSERT, tbl_stamp[$urandom_range(0, 40)] + 1,
                             rand_pose(), 0, none);
                3: push_item(ntpb_pkg::OP_INSERT, 63'd0, rand_pose(), 0, none);
                default: push_item(ntpb_pkg::OP_LOOKUP, pick_query(), rand_pose(), 0, none);
            endcase
        end
        for (int i = 0; i < 4; i++) begin
            cursor = cursor + $urandom_range(1, 1000);
            push_item(ntpb_pkg::OP_INSERT, cursor, rand_pose(), 0, none);
            push_item(ntpb_pkg::OP_LOOKUP, tbl_stamp[0], rand_pose(), 0, none);
        end

        drain();
        repeat (64) @(posedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
